// File: hdl/circle_vertex_generator_assert.svh
// ----------------------------------------------------------------------------
// circle vertex generator assertion macros
// concurrent checks on a clock with an active-low synchronous reset
// ----------------------------------------------------------------------------
`ifndef CIRCLE_VERTEX_GENERATOR_ASSERT_SVH
`define CIRCLE_VERTEX_GENERATOR_ASSERT_SVH

// condition implies consequence in the same cycle
`define CVG_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define CVG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/cvg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvg_pkg
// shared widths, register indexes, reset values, sideband type, arctangent table and coordinate clamp
// ----------------------------------------------------------------------------
package cvg_pkg;

  localparam int ANGLE_BITS  = 20;
  localparam int RADIUS_BITS = 16;
  localparam int FRAC_BITS   = 16;
  localparam int INDEX_W     = 12;
  localparam int COUNT_W     = 13;
  localparam int STEP_W      = 21;
  localparam int COORD_W     = RADIUS_BITS + 1;

  // datapath formats
  localparam int XY_W  = 35;                  // x, y with 16 fraction bits
  localparam int Z_W   = 33;                  // angle residual, 2^-32 turn units
  localparam int RND_W = XY_W - FRAC_BITS;    // rounded coordinate
  localparam int PRE_W = RND_W + 1;           // after quadrant negation
  localparam int GAIN_W = 30;
  localparam int GPROD_W = RADIUS_BITS + GAIN_W;
  localparam int APROD_W = INDEX_W + STEP_W;

  localparam logic [GAIN_W-1:0]  INV_GAIN     = 30'd652032874;
  localparam logic [COUNT_W-1:0] MAX_VERTICES = 13'd4096;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = STEP_W;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP   = 2'd2;

  localparam logic [RADIUS_BITS-1:0] RADIUS_RST = 16'd0;
  localparam logic [COUNT_W-1:0]     COUNT_RST  = 13'd36;
  localparam logic [STEP_W-1:0]      STEP_RST   = 21'd29127;

  typedef struct packed {
    logic [1:0] quad;
    logic       last;
    logic       oor;
  } side_t;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic signed [Z_W-1:0] atan_turn(input int i);
    logic signed [Z_W-1:0] v;
    case (i)
      0:  v = 33'sh020000000;
      1:  v = 33'sh012E4051E;
      2:  v = 33'sh009FB385B;
      3:  v = 33'sh0051111D4;
      4:  v = 33'sh0028B0D43;
      5:  v = 33'sh00145D7E1;
      6:  v = 33'sh000A2F61E;
      7:  v = 33'sh000517C55;
      8:  v = 33'sh00028BE53;
      9:  v = 33'sh000145F2F;
      10: v = 33'sh0000A2F98;
      11: v = 33'sh0000517CC;
      12: v = 33'sh000028BE6;
      13: v = 33'sh0000145F3;
      14: v = 33'sh000000A2FA;
      15: v = 33'sh00000517D;
      16: v = 33'sh0000028BE;
      17: v = 33'sh00000145F;
      18: v = 33'sh000000A30;
      19: v = 33'sh000000518;
      20: v = 33'sh00000028C;
      21: v = 33'sh000000146;
      22: v = 33'sh0000000A3;
      23: v = 33'sh000000051;
      24: v = 33'sh000000029;
      25: v = 33'sh000000014;
      26: v = 33'sh00000000A;
      27: v = 33'sh000000005;
      28: v = 33'sh000000003;
      29: v = 33'sh000000001;
      30: v = 33'sh000000001;
      default: v = '0;
    endcase
    return v;
  endfunction

  // clamp to +-(2^RADIUS_BITS - 1)
  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [PRE_W-1:0] v);
    logic signed [PRE_W-1:0] hi;
    logic signed [PRE_W-1:0] lo;
    logic signed [COORD_W-1:0] r;
    hi = PRE_W'((1 << RADIUS_BITS) - 1);
    lo = -hi;
    if (v > hi) begin
      r = hi[COORD_W-1:0];
    end else if (v < lo) begin
      r = lo[COORD_W-1:0];
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: hdl/cvg_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvg_cordic
// rotation-mode cordic pipeline, one micro-rotation per register stage
// ----------------------------------------------------------------------------
module cvg_cordic
  import cvg_pkg::*;
#(
  parameter int STAGES = 18
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic signed [XY_W-1:0] in_x,
  input  logic signed [XY_W-1:0] in_y,
  input  logic signed [Z_W-1:0]  in_z,
  input  side_t                 in_side,
  output logic                  out_valid,
  output logic signed [XY_W-1:0] out_x,
  output logic signed [XY_W-1:0] out_y,
  output side_t                 out_side
);

  logic                   v_r    [STAGES];
  logic signed [XY_W-1:0] x_r    [STAGES];
  logic signed [XY_W-1:0] y_r    [STAGES];
  logic signed [Z_W-1:0]  z_r    [STAGES];
  side_t                  side_r [STAGES];

  for (genvar gk = 0; gk < STAGES; gk++) begin : g_stage
    localparam logic signed [Z_W-1:0] ATAN_K = atan_turn(gk);
    logic                   vi;
    logic signed [XY_W-1:0] xi, yi, dx, dy;
    logic signed [Z_W-1:0]  zi;
    side_t                  si;

    if (gk == 0) begin : g_first
      assign vi = in_valid;
      assign xi = in_x;
      assign yi = in_y;
      assign zi = in_z;
      assign si = in_side;
    end else begin : g_next
      assign vi = v_r[gk-1];
      assign xi = x_r[gk-1];
      assign yi = y_r[gk-1];
      assign zi = z_r[gk-1];
      assign si = side_r[gk-1];
    end

    assign dx = yi >>> gk;
    assign dy = xi >>> gk;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[gk] <= 1'b0;
      end else if (en) begin
        v_r[gk] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[gk] <= si;
        // rotate toward zero residual angle
        if (!zi[Z_W-1]) begin
          x_r[gk] <= xi - dx;
          y_r[gk] <= yi + dy;
          z_r[gk] <= zi - ATAN_K;
        end else begin
          x_r[gk] <= xi + dx;
          y_r[gk] <= yi - dy;
          z_r[gk] <= zi + ATAN_K;
        end
      end
    end
  end

  assign out_valid = v_r[STAGES-1];
  assign out_x     = x_r[STAGES-1];
  assign out_y     = y_r[STAGES-1];
  assign out_side  = side_r[STAGES-1];

endmodule

// File: hdl/circle_vertex_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_vertex_generator
// streams circle points (radius*cos, radius*sin) for incoming vertex indices
// ----------------------------------------------------------------------------
// usage:
//   in_*   : one vertex index per item, accepted on in_tvalid & in_tready
//   out_*  : x/y point per item, out_tlast marks the last vertex of the
//            circle, out_tuser flags an index at or beyond the vertex count
//   cfg_*  : register writes (radius, vertex count, angle step), always
//            ready; write only while no item is in flight
// pipeline: from accept to out_tvalid an item passes the angle multiply
//   stage, CORDIC_STAGES cordic stages with one micro-rotation each, and
//   the rounding, quadrant and output stages
// throughput: one item per cycle while the skid register is empty
// reset: pipeline and output empty, radius 0, count 36, step 29127
// stall: a finished item waits in the output register and one more in a
//   skid register; with both full in_tready drops and the pipeline holds
// ----------------------------------------------------------------------------
`include "circle_vertex_generator_assert.svh"

module circle_vertex_generator
  import cvg_pkg::*;
#(
  parameter int CORDIC_STAGES = 18
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input items
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,    // [11:0] vertex_index
  // result items
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [39:0]           out_tdata,   // [16:0] x_coord, [33:17] y_coord
  output logic                  out_tlast,   // last_vertex
  output logic                  out_tuser,   // index_out_of_range
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration registers
  logic [RADIUS_BITS-1:0] radius_r;
  logic [COUNT_W-1:0]     count_r;
  logic [STEP_W-1:0]      step_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RST;
      count_r  <= COUNT_RST;
      step_r   <= STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RADIUS: radius_r <= cfg_data[RADIUS_BITS-1:0];
        REG_COUNT:  count_r  <= cfg_data[COUNT_W-1:0];
        REG_STEP:   step_r   <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advances while the skid register is empty
  logic skid_valid_r;
  logic en;

  assign en        = !skid_valid_r;
  assign in_tready = en;

  // stage 0: angle product, start vector, index flags
  logic [INDEX_W-1:0] vidx;
  logic [APROD_W-1:0] ang_prod;
  logic [GPROD_W-1:0] gain_prod;
  logic [COUNT_W-1:0] count_eff;
  side_t              side0;

  assign vidx      = in_tdata[INDEX_W-1:0];
  assign ang_prod  = APROD_W'(vidx) * APROD_W'(step_r);
  assign gain_prod = GPROD_W'(radius_r) * GPROD_W'(INV_GAIN);
  assign count_eff = (count_r > MAX_VERTICES) ? MAX_VERTICES : count_r;

  always_comb begin
    side0.quad = ang_prod[ANGLE_BITS-1:ANGLE_BITS-2];
    side0.last = (count_eff != '0) && (COUNT_W'(vidx) == count_eff - COUNT_W'(1));
    side0.oor  = COUNT_W'(vidx) >= count_eff;
  end

  logic                   s0_valid_r;
  logic signed [XY_W-1:0] s0_x_r;
  logic signed [Z_W-1:0]  s0_z_r;
  side_t                  s0_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (en) begin
      s0_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // start vector radius * inverse gain with 16 fraction bits
      s0_x_r    <= XY_W'(gain_prod[GPROD_W-1:GAIN_W-FRAC_BITS]);
      // residual below a quarter turn, scaled to 2^-32 turn
      s0_z_r    <= Z_W'({ang_prod[ANGLE_BITS-3:0], (32 - ANGLE_BITS)'(0)});
      s0_side_r <= side0;
    end
  end

  // rotation
  logic                   c_valid;
  logic signed [XY_W-1:0] c_x, c_y;
  side_t                  c_side;

  cvg_cordic #(
    .STAGES(CORDIC_STAGES)
  ) u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (s0_valid_r),
    .in_x     (s0_x_r),
    .in_y     ('0),
    .in_z     (s0_z_r),
    .in_side  (s0_side_r),
    .out_valid(c_valid),
    .out_x    (c_x),
    .out_y    (c_y),
    .out_side (c_side)
  );

  // round half up to output units
  logic signed [XY_W-1:0] x_half, y_half;
  logic                   r_valid_r;
  logic signed [RND_W-1:0] rx_r, ry_r;
  side_t                  r_side_r;

  assign x_half = c_x + XY_W'(1 << (FRAC_BITS - 1));
  assign y_half = c_y + XY_W'(1 << (FRAC_BITS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_valid_r <= 1'b0;
    end else if (en) begin
      r_valid_r <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx_r     <= x_half[XY_W-1:FRAC_BITS];
      ry_r     <= y_half[XY_W-1:FRAC_BITS];
      r_side_r <= c_side;
    end
  end

  // quadrant turn
  logic signed [PRE_W-1:0] rx_w, ry_w, qx, qy;
  logic                    q_valid_r;
  logic signed [PRE_W-1:0] qx_r, qy_r;
  logic                    q_last_r, q_oor_r;

  assign rx_w = PRE_W'(rx_r);
  assign ry_w = PRE_W'(ry_r);

  always_comb begin
    case (r_side_r.quad)
      2'd0: begin qx = rx_w;  qy = ry_w;  end
      2'd1: begin qx = -ry_w; qy = rx_w;  end
      2'd2: begin qx = -rx_w; qy = -ry_w; end
      default: begin qx = ry_w; qy = -rx_w; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_valid_r <= 1'b0;
    end else if (en) begin
      q_valid_r <= r_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qx_r     <= qx;
      qy_r     <= qy;
      q_last_r <= r_side_r.last && !r_side_r.oor;
      q_oor_r  <= r_side_r.oor;
    end
  end

  // saturation into the output register, skid register behind it
  logic signed [COORD_W-1:0] sx, sy;
  logic                      take;
  logic                      out_valid_r;
  logic signed [COORD_W-1:0] out_x_r, out_y_r;
  logic                      out_last_r, out_oor_r;
  logic signed [COORD_W-1:0] skid_x_r, skid_y_r;
  logic                      skid_last_r, skid_oor_r;

  assign sx   = sat_coord(qx_r);
  assign sy   = sat_coord(qy_r);
  assign take = out_valid_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (q_valid_r) begin
      if (!out_valid_r || take) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (take) begin
        out_x_r    <= skid_x_r;
        out_y_r    <= skid_y_r;
        out_last_r <= skid_last_r;
        out_oor_r  <= skid_oor_r;
      end
    end else if (q_valid_r) begin
      if (!out_valid_r || take) begin
        out_x_r    <= sx;
        out_y_r    <= sy;
        out_last_r <= q_last_r;
        out_oor_r  <= q_oor_r;
      end else begin
        skid_x_r    <= sx;
        skid_y_r    <= sy;
        skid_last_r <= q_last_r;
        skid_oor_r  <= q_oor_r;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_y_r, out_x_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_oor_r;

  // checks
  `CVG_ASSERT_SAME(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r,
                   "skid register full while output register empty")
  `CVG_ASSERT_NEXT(a_skid_holds, clk, rst_n, skid_valid_r && !out_tready, skid_valid_r,
                   "skid item dropped without a transfer")
  `CVG_ASSERT_SAME(a_last_in_range, clk, rst_n, out_tvalid && out_tuser, !out_tlast,
                   "last vertex flagged on an out-of-range index")

endmodule

// File: tb/circle_vertex_generator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_vertex_generator_test
// streams vertex indices through the circle point generator and checks each
// point against a bit-exact cordic predictor or a typed point; settings change
// only between drained batches, in four idling phases and one long output hold
// ----------------------------------------------------------------------------
module circle_vertex_generator_test;
  import cvg_pkg::*;

  localparam int  HALF_PERIOD    = 5;
  localparam int  RESET_CYCLES   = 12;
  localparam int  IDLE_GAP       = 30;     // pipeline depth plus margin
  localparam int  TAIL_CYCLES    = 30;
  localparam int  WATCHDOG_LIMIT = 3000;
  localparam int  HOLD_CYCLES    = 300;
  localparam int  PHASE_ITEMS    = 400;
  localparam int  STAGES         = 18;
  localparam int  COUNT_CAP      = 4096;
  localparam longint GAIN_Q30    = 64'd652032874;
  localparam longint COORD_LIM   = 64'd65535;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // arctangent of 2^-i, units of 2^-32 turn
  localparam longint ATAN_TURN [0:STAGES-1] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
    64'h000028BE, 64'h0000145F
  };

  localparam int SEND_IDLE  [0:3] = '{0, 53, 0, 28};
  localparam int RECV_STALL [0:3] = '{0, 0, 53, 28};

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      last;
    logic                      oor;
  } point_t;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_e;

  typedef struct {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_DATA_W-1:0]  value;
    logic [INDEX_W-1:0]     idx;
    bit                     typed;
    point_t                 want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [15:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic out_tlast;
  logic out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // testbench copy of the registers
  logic [RADIUS_BITS-1:0] cur_radius = 16'd0;
  logic [COUNT_W-1:0]     cur_count  = 13'd36;
  logic [STEP_W-1:0]      cur_step   = 21'd29127;

  point_t pending_points [$];
  int mismatches = 0;
  int items_sent = 0;
  int points_seen = 0;
  int reg_writes = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;
  point_t got_pt;
  point_t want_pt;

  circle_vertex_generator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic point_t cordic_point(input logic [INDEX_W-1:0] idx);
    logic [APROD_W-1:0] prod;
    logic [ANGLE_BITS-1:0] ang;
    logic [1:0] quad;
    longint x, y, z, dx, dy, rx, ry, ox, oy;
    int count;
    point_t p;
    prod = APROD_W'(idx) * APROD_W'(cur_step);
    ang = prod[ANGLE_BITS-1:0];
    quad = ang[ANGLE_BITS-1:ANGLE_BITS-2];
    z = longint'(ang[ANGLE_BITS-3:0]) << (32 - ANGLE_BITS);
    // start at radius / gain so the rotation lands on the radius
    x = longint'((64'(cur_radius) * GAIN_Q30) >> (30 - FRAC_BITS));
    y = 0;
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= ATAN_TURN[i];
      end else begin
        x += dx;
        y -= dy;
        z += ATAN_TURN[i];
      end
    end
    rx = (x + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    ry = (y + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    case (quad)
      2'd0: begin ox = rx;  oy = ry;  end
      2'd1: begin ox = -ry; oy = rx;  end
      2'd2: begin ox = -rx; oy = -ry; end
      default: begin ox = ry; oy = -rx; end
    endcase
    if (ox > COORD_LIM) ox = COORD_LIM;
    if (ox < -COORD_LIM) ox = -COORD_LIM;
    if (oy > COORD_LIM) oy = COORD_LIM;
    if (oy < -COORD_LIM) oy = -COORD_LIM;
    count = (int'(cur_count) > COUNT_CAP) ? COUNT_CAP : int'(cur_count);
    p.x = ox[COORD_W-1:0];
    p.y = oy[COORD_W-1:0];
    p.last = (count != 0) && (int'(idx) == count - 1);
    p.oor = int'(idx) >= count;
    return p;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // result side: compare against the oldest expected point
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_pt.x = out_tdata[16:0];
      got_pt.y = out_tdata[33:17];
      got_pt.last = out_tlast;
      got_pt.oor = out_tuser;
      points_seen++;
      if (pending_points.size() == 0) begin
        $display("%0t: unexpected point, expected none, got x %0d y %0d", $time,
                 got_pt.x, got_pt.y);
        mismatches++;
      end else begin
        want_pt = pending_points.pop_front();
        check_field("x_coord", longint'(want_pt.x), longint'(got_pt.x));
        check_field("y_coord", longint'(want_pt.y), longint'(got_pt.y));
        check_field("last_vertex", longint'(want_pt.last), longint'(got_pt.last));
        check_field("index_out_of_range", longint'(want_pt.oor), longint'(got_pt.oor));
      end
    end
  end

  // receiver: random stalls, or a long hold-off when requested
  always @(negedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no handshake for %0d cycles, %0d points outstanding",
               $time, quiet_cycles, pending_points.size());
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_vertex(input logic [INDEX_W-1:0] idx, input point_t want);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0000, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_points.push_back(want);
    items_sent++;
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] ridx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= ridx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (ridx)
      REG_RADIUS: cur_radius = data[RADIUS_BITS-1:0];
      REG_COUNT:  cur_count = data[COUNT_W-1:0];
      REG_STEP:   cur_step = data;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // stop offering items and let every outstanding point come out
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (IDLE_GAP) @(posedge clk);
  endtask

  initial begin : stimulus
    row_t dir_rows [$];
    point_t want;
    int sel, cnt, stp, lo, phase_items;
    logic [RADIUS_BITS-1:0] rad;
    logic [INDEX_W-1:0] idx;

    dir_rows = '{
      // reset settings: radius zero, so every point is the origin
      '{ROW_ITEM, REG_RADIUS, 21'd0, 12'd0,    1'b1, '{17'sd0, 17'sd0, 1'b0, 1'b0}},
      '{ROW_ITEM, REG_RADIUS, 21'd0, 12'd35,   1'b1, '{17'sd0, 17'sd0, 1'b1, 1'b0}},
      '{ROW_ITEM, REG_RADIUS, 21'd0, 12'd36,   1'b1, '{17'sd0, 17'sd0, 1'b0, 1'b1}},
      '{ROW_ITEM, REG_RADIUS, 21'd0, 12'd4095, 1'b1, '{17'sd0, 17'sd0, 1'b0, 1'b1}},
      // zero vertex count: everything out of range, never last
      '{ROW_CFG,  REG_COUNT,  21'd0, 12'd0,    1'b0, '0},
      '{ROW_ITEM, REG_RADIUS, 21'd0, 12'd0,    1'b1, '{17'sd0, 17'sd0, 1'b0, 1'b1}},
      '{ROW_ITEM, REG_RADIUS, 21'd0, 12'd4095, 1'b1, '{17'sd0, 17'sd0, 1'b0, 1'b1}},
      // full radius, full count, quadrant boundaries
      '{ROW_CFG,  REG_RADIUS, 21'd65535, 12'd0, 1'b0, '0},
      '{ROW_CFG,  REG_COUNT,  21'd4096,  12'd0, 1'b0, '0},
      '{ROW_CFG,  REG_STEP,   21'd256,   12'd0, 1'b0, '0},
      '{ROW_ITEM, REG_RADIUS, 21'd0, 12'd0,    1'b0, '0},
      '{ROW_ITEM, REG_RADIUS, 21'd0, 12'd1024, 1'b0, '0},
      '{ROW_ITEM, REG_RADIUS, 21'd0, 12'd2048, 1'b0, '0},
      '{ROW_ITEM, REG_RADIUS, 21'd0, 12'd3072, 1'b0, '0},
      '{ROW_ITEM, REG_RADIUS, 21'd0, 12'd4095, 1'b0, '0},
      '{ROW_ITEM, REG_RADIUS, 21'd0, 12'd2730, 1'b0, '0},
      // count above the maximum behaves as the maximum
      '{ROW_CFG,  REG_COUNT,  21'd8191, 12'd0, 1'b0, '0},
      '{ROW_ITEM, REG_RADIUS, 21'd0, 12'd4095, 1'b0, '0},
      '{ROW_ITEM, REG_RADIUS, 21'd0, 12'd1365, 1'b0, '0},
      // oversized steps wrap with the product
      '{ROW_CFG,  REG_STEP,   21'h1FFFFF, 12'd0, 1'b0, '0},
      '{ROW_ITEM, REG_RADIUS, 21'd0, 12'd4095, 1'b0, '0},
      '{ROW_ITEM, REG_RADIUS, 21'd0, 12'd1,    1'b0, '0},
      '{ROW_CFG,  REG_STEP,   21'h100000, 12'd0, 1'b0, '0},
      '{ROW_ITEM, REG_RADIUS, 21'd0, 12'd3,    1'b0, '0},
      '{ROW_CFG,  REG_STEP,   21'd0, 12'd0, 1'b0, '0},
      '{ROW_ITEM, REG_RADIUS, 21'd0, 12'd7,    1'b0, '0},
      // write to the unused index must change nothing
      '{ROW_CFG,  REG_UNUSED, 21'h1FFFFF, 12'd0, 1'b0, '0},
      '{ROW_ITEM, REG_RADIUS, 21'd0, 12'd7,    1'b0, '0},
      // single vertex, smallest radius
      '{ROW_CFG,  REG_RADIUS, 21'd1, 12'd0, 1'b0, '0},
      '{ROW_CFG,  REG_COUNT,  21'd1, 12'd0, 1'b0, '0},
      '{ROW_CFG,  REG_STEP,   21'd349525, 12'd0, 1'b0, '0},
      '{ROW_ITEM, REG_RADIUS, 21'd0, 12'd0, 1'b0, '0},
      '{ROW_ITEM, REG_RADIUS, 21'd0, 12'd1, 1'b0, '0},
      '{ROW_ITEM, REG_RADIUS, 21'd0, 12'd2, 1'b0, '0},
      // upper data bits of a radius write are dropped, leaving zero
      '{ROW_CFG,  REG_RADIUS, 21'h1F0000, 12'd0, 1'b0, '0},
      '{ROW_ITEM, REG_RADIUS, 21'd0, 12'd5, 1'b1, '{17'sd0, 17'sd0, 1'b0, 1'b1}}
    };

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        wait_idle();
        cfg_write(dir_rows[r].reg_idx, dir_rows[r].value);
      end else begin
        want = dir_rows[r].typed ? dir_rows[r].want : cordic_point(dir_rows[r].idx);
        send_vertex(dir_rows[r].idx, want);
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      send_idle_pct = SEND_IDLE[ph];
      recv_stall_pct = RECV_STALL[ph];
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        wait_idle();
        sel = $urandom_range(99);
        rad = (sel < 10) ? 16'd0 : (sel < 20) ? 16'hFFFF : 16'($urandom_range(65535));
        cfg_write(REG_RADIUS, {5'($urandom_range(31)), rad});
        sel = $urandom_range(99);
        if (sel < 75) begin
          // whole circle at the nominal step, or the tail of a large one
          cnt = (sel < 65) ? $urandom_range(3, 40) : $urandom_range(41, COUNT_CAP);
          stp = ((1 << ANGLE_BITS) + cnt / 2) / cnt;
          cfg_write(REG_COUNT, 21'(cnt));
          cfg_write(REG_STEP, 21'(stp));
        end else begin
          sel = $urandom_range(99);
          cnt = (sel < 10) ? 0 : (sel < 20) ? $urandom_range(4097, 8191) :
                (sel < 25) ? COUNT_CAP : $urandom_range(1, COUNT_CAP);
          sel = $urandom_range(99);
          stp = (sel < 5) ? 0 : (sel < 10) ? 21'h1FFFFF : $urandom_range(0, 21'h1FFFFF);
          cfg_write(REG_COUNT, 21'(cnt));
          cfg_write(REG_STEP, 21'(stp));
          cnt = -1;
        end
        if (ph == 0 && phase_items == 0) begin
          // hold the output long enough that the block backs up
          @(posedge clk);
          hold_token++;
          repeat (64) begin
            idx = 12'($urandom_range(4095));
            send_vertex(idx, cordic_point(idx));
          end
          phase_items += 64;
        end else if (cnt < 0) begin
          repeat (32) begin
            idx = 12'($urandom_range(4095));
            send_vertex(idx, cordic_point(idx));
          end
          phase_items += 32;
        end else begin
          lo = (cnt > 48) ? cnt - 32 : 0;
          for (int k = lo; k < cnt; k++) begin
            send_vertex(12'(k), cordic_point(12'(k)));
          end
          phase_items += cnt - lo;
        end
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("run covered %0d vertex items and %0d points, %0d register writes,",
             items_sent, points_seen, reg_writes);
    $display("over four idling phases and one long output hold-off; %0d mismatches",
             mismatches);
    if (mismatches == 0 && pending_points.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
